### hdl/rstc_pkg.sv
// Shared types and constants for the ratio spanning tree check block.
// No dependencies.
package rstc_pkg;
  localparam int SCORE_W = 33;
  localparam int INFO_W  = 36;
  localparam int SUM_W   = 18;
  localparam int RANK_W  = 4;
  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic [SUM_W-1:0]  SUM_MAX  = 18'h3FFFF;
  localparam logic [0:0] CFG_RATIO = 1'b0;
  localparam logic [0:0] CFG_VERTS = 1'b1;

  // sort key: score compared first (signed), then packed info on a tie
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [INFO_W-1:0]         info;
  } edge_key_t;

  function automatic logic key_gt(edge_key_t x, edge_key_t y);
    if (x.score != y.score) return x.score > y.score;
    return x.info > y.info;
  endfunction
endpackage

### hdl/ratio_spanning_tree_check.sv
// Ratio spanning tree check: edge store, in-place sorter and union-find sequencer.
// Depends on rstc_pkg.
//
// Usage: edges enter on the in_ channel, one word per cycle while loading.
// A word with in_last_edge set ends the batch. in_stall then stays high while
// the block sorts the stored edges and runs union-find.
// Sorting is an insertion sort in place in the edge memory. Each edge moves
// toward the front past every earlier edge whose key is smaller, so keys
// end up in descending order.
// Clearing the forest writes vertices_in_use entries (capped at
// MAX_VERTICES), one entry a cycle, at least one. Union-find skips an edge
// with an endpoint out of range. Any other edge walks to the root of each
// endpoint and runs a compression pass on each walk, then joins the two
// roots if they differ. A multiply state and an output state form the result.
// The result is one word on the out_ channel: feasible and both sums. It
// sits in an output register until taken. The next batch may load meanwhile.
// While out_stall holds an earlier word, a finished batch waits before
// returning to load.
// Reset (rst_n low, synchronous) empties the edge store, sets the ratio to
// zero and vertices_in_use to 1024. Forest tables are cleared per batch.
// Configuration words on cfg_ are taken whenever cfg_valid is high.
module ratio_spanning_tree_check #(
  parameter int MAX_EDGES    = 1024,
  parameter int MAX_VERTICES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [9:0]               in_end_a,
  input  logic [9:0]               in_end_b,
  input  logic [7:0]               in_profit,
  input  logic [7:0]               in_weight,
  input  logic signed [32:0]       in_edge_score,
  input  logic                     in_last_edge,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_feasible,
  output logic [17:0]              out_profit_total,
  output logic [17:0]              out_weight_total,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [23:0]              cfg_data
);
  import rstc_pkg::*;

  localparam int EW = $clog2(MAX_EDGES);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = EW + 1;

  typedef enum logic [4:0] {
    S_LOAD, S_S_INIT, S_S_CUR, S_S_CMP, S_S_PUT,
    S_CLR, S_U_RD, S_U_CHK,
    S_F_RD, S_F_CHK, S_C_RD, S_C_WR,
    S_JOIN, S_JOIN2, S_MUL, S_OUT
  } state_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [VW-1:0]     parent;
  } node_t;

  state_t state_r;

  // edge and forest memories
  edge_key_t key_mem  [MAX_EDGES];
  node_t     node_mem [MAX_VERTICES];

  logic [23:0]   ratio_r;
  logic [10:0]   verts_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] i_r, k_r;
  logic [VW:0]   nv_r;
  edge_key_t     cur_key_r, rd_key_r;
  node_t         rd_node_r;
  logic [VW-1:0] v_r, root_a_r, root_b_r, walk_r;
  logic          side_r;
  logic [VW-1:0] end_b_r;
  logic [7:0]    p_r, w_r;
  logic [RANK_W-1:0] rank_w_r, rank_a_r, rank_b_r;
  logic [SUM_W-1:0]  psum_r, wsum_r;
  logic [41:0]   rhs_r;

  // memory port controls
  logic          key_we, node_we;
  logic [EW-1:0] key_wa, key_ra;
  edge_key_t     key_wd;
  logic [VW-1:0] node_wa, node_ra;
  node_t         node_wd;

  logic [VW:0]   nv_clamp;
  logic          in_take, key_more, rd_out;
  logic [EW-1:0] i_idx, k_idx, km1, km2;
  logic [9:0]    rd_a, rd_b;
  logic [SUM_W:0] psum_add, wsum_add;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_LOAD);
  assign in_take   = in_valid && !in_stall;
  assign i_idx = i_r[EW-1:0];
  assign k_idx = k_r[EW-1:0];
  assign km1   = EW'(k_r - CW'(1));
  assign km2   = EW'(k_r - CW'(2));
  assign nv_clamp = (32'(verts_r) > MAX_VERTICES) ? (VW+1)'(MAX_VERTICES)
                                                  : (VW+1)'(verts_r);
  assign key_more = key_gt(cur_key_r, rd_key_r);
  assign rd_a   = rd_key_r.info[19:10];
  assign rd_b   = rd_key_r.info[9:0];
  assign rd_out = (32'(rd_a) >= 32'(nv_r)) || (32'(rd_b) >= 32'(nv_r));
  assign psum_add = {1'b0, psum_r} + (SUM_W+1)'(p_r);
  assign wsum_add = {1'b0, wsum_r} + (SUM_W+1)'(w_r);

  always_ff @(posedge clk) begin
    if (key_we) key_mem[key_wa] <= key_wd;
    rd_key_r <= key_mem[key_ra];
    if (node_we) node_mem[node_wa] <= node_wd;
    rd_node_r <= node_mem[node_ra];
  end

  always_comb begin
    key_we = 1'b0; key_wa = k_idx; key_ra = i_idx; key_wd = rd_key_r;
    node_we = 1'b0; node_wa = v_r; node_ra = v_r;
    node_wd = '{rank: rd_node_r.rank, parent: walk_r};
    unique case (state_r)
      S_LOAD: begin
        key_we = in_take && (32'(count_r) < MAX_EDGES);
        key_wa = count_r[EW-1:0];
        key_wd = '{score: in_edge_score,
                   info: {in_profit, in_weight, in_end_a, in_end_b}};
      end
      S_S_INIT: key_ra = i_idx;
      S_S_CUR:  key_ra = km1;
      S_S_CMP: begin
        key_we = key_more;
        key_ra = km2;
      end
      S_S_PUT: begin
        key_we = 1'b1; key_wd = cur_key_r;
      end
      S_CLR: begin
        node_we = 1'b1; node_wd = '{rank: RANK_W'(1), parent: v_r};
      end
      S_U_RD:   key_ra = i_idx;
      S_F_RD:   node_ra = walk_r;
      S_C_RD:   node_ra = v_r;
      S_C_WR:   node_we = (v_r != walk_r) && (rd_node_r.parent != walk_r);
      S_JOIN: begin
        node_we = 1'b1;
        if (rank_a_r < rank_b_r) begin
          node_wa = root_a_r; node_wd = '{rank: rank_a_r, parent: root_b_r};
        end else begin
          node_wa = root_b_r; node_wd = '{rank: rank_b_r, parent: root_a_r};
        end
      end
      S_JOIN2: begin
        node_we = 1'b1; node_wa = root_a_r;
        node_wd = '{rank: rank_a_r + 1'b1, parent: root_a_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      out_valid <= 1'b0;
      ratio_r   <= '0;
      verts_r   <= 11'd1024;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_RATIO: ratio_r <= cfg_data;
          CFG_VERTS: verts_r <= cfg_data[10:0];
        endcase
      end
      if (out_valid && !out_stall && state_r != S_OUT) out_valid <= 1'b0;
      unique case (state_r)
        S_LOAD: if (in_take) begin
          if (32'(count_r) < MAX_EDGES) count_r <= count_r + 1'b1;
          if (in_last_edge) begin
            state_r <= S_S_INIT;
            i_r <= CW'(1);
          end
        end
        S_S_INIT: begin
          if (i_r >= count_r) begin
            state_r <= S_CLR;
            v_r <= '0;
            nv_r <= nv_clamp;
          end else begin
            k_r <= i_r;
            state_r <= S_S_CUR;
          end
        end
        S_S_CUR: begin
          cur_key_r <= rd_key_r;
          state_r <= S_S_CMP;
        end
        S_S_CMP: begin
          if (key_more) begin
            k_r <= k_r - 1'b1;
            if (k_r == CW'(1)) state_r <= S_S_PUT;
          end else state_r <= S_S_PUT;
        end
        S_S_PUT: begin
          i_r <= i_r + 1'b1;
          state_r <= S_S_INIT;
        end
        S_CLR: begin
          if (32'(v_r) + 1 >= 32'(nv_r)) begin
            psum_r <= '0; wsum_r <= '0; i_r <= '0;
            state_r <= S_U_RD;
          end else v_r <= v_r + 1'b1;
        end
        S_U_RD: begin
          if (i_r == count_r) state_r <= S_MUL;
          else state_r <= S_U_CHK;
        end
        S_U_CHK: begin
          p_r <= rd_key_r.info[35:28];
          w_r <= rd_key_r.info[27:20];
          end_b_r <= VW'(rd_b);
          if (rd_out) begin
            i_r <= i_r + 1'b1;
            state_r <= S_U_RD;
          end else begin
            side_r <= 1'b0;
            walk_r <= VW'(rd_a);
            v_r <= VW'(rd_a);
            state_r <= S_F_RD;
          end
        end
        S_F_RD: state_r <= S_F_CHK;
        S_F_CHK: begin
          if (rd_node_r.parent == walk_r) begin
            rank_w_r <= rd_node_r.rank;
            state_r <= S_C_RD;
          end else begin
            walk_r <= rd_node_r.parent;
            state_r <= S_F_RD;
          end
        end
        S_C_RD: state_r <= S_C_WR;
        S_C_WR: begin
          if (v_r == walk_r || rd_node_r.parent == walk_r) begin
            if (!side_r) begin
              root_a_r <= walk_r;
              rank_a_r <= rank_w_r;
              side_r <= 1'b1;
              walk_r <= end_b_r;
              v_r <= end_b_r;
              state_r <= S_F_RD;
            end else if (root_a_r == walk_r) begin
              i_r <= i_r + 1'b1;
              state_r <= S_U_RD;
            end else begin
              root_b_r <= walk_r;
              rank_b_r <= rank_w_r;
              state_r <= S_JOIN;
            end
          end else begin
            v_r <= rd_node_r.parent;
            state_r <= S_C_RD;
          end
        end
        S_JOIN: begin
          psum_r <= psum_add[SUM_W] ? SUM_MAX : psum_add[SUM_W-1:0];
          wsum_r <= wsum_add[SUM_W] ? SUM_MAX : wsum_add[SUM_W-1:0];
          if (rank_a_r == rank_b_r && rank_a_r < RANK_MAX) state_r <= S_JOIN2;
          else begin
            i_r <= i_r + 1'b1;
            state_r <= S_U_RD;
          end
        end
        S_JOIN2: begin
          i_r <= i_r + 1'b1;
          state_r <= S_U_RD;
        end
        S_MUL: begin
          rhs_r <= 42'(ratio_r) * 42'(wsum_r);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_feasible <= (42'({psum_r, 16'h0}) >= rhs_r);
            out_profit_total <= psum_r;
            out_weight_total <= wsum_r;
            count_r <= '0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

### hdl/rstc_checker.sv
// Port-level checker for ratio_spanning_tree_check, with its bind.
// Depends on nothing but the top level's ports.
module rstc_props (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic in_last_edge,
  input logic out_valid,
  input logic out_stall
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_edge |=> in_stall) else $error("no stall");
  a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> !$rose(out_valid)) else $error("result without batch");
endmodule

bind ratio_spanning_tree_check rstc_props u_chk (.*);
